### rtl/rwct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_pkg
// Shared types, codes and helpers of the wall column texturer.
// ----------------------------------------------------------------------------
package rwct_pkg;

  // Operation codes of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  // Pixel region codes
  localparam logic [1:0] REGION_CEILING = 2'd0;
  localparam logic [1:0] REGION_WALL    = 2'd1;
  localparam logic [1:0] REGION_FLOOR   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_FLOOR   = 1'b1;

  // Restoring divider: (tex_height << 16) / wall_span gives a 27-bit quotient
  localparam int DIV_STEPS = 27;
  localparam int DIV_CNT_W = 5;

  localparam int PROD_W = 45;
  localparam logic signed [PROD_W-1:0] Q_MAX = 45'sd2147483647;
  localparam logic signed [PROD_W-1:0] Q_MIN = -45'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT,
    S_FRAC,
    S_DIV,
    S_POS,
    S_ARM
  } rwct_state_t;

  typedef struct packed {
    logic load_capture;
    logic hit_mul;
    logic col_mul;
    logic div_step;
    logic col_write;
    logic pos_mul;
    logic arm;
    logic row_fire;
  } rwct_cmd_t;

  function automatic logic signed [31:0] sat_q16(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > Q_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < Q_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Texture size: zero reads as one, anything above 1024 as 1024
  function automatic logic [10:0] tex_size(input logic [10:0] v);
    logic [10:0] r;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > 11'd1024) begin
      r = 11'd1024;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/rwct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_in_if / rwct_out_if
// Valid/ready channels for column descriptors and row requests, and pixels.
// ----------------------------------------------------------------------------
interface rwct_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               side;
  logic [23:0]        pos_x;
  logic [23:0]        pos_y;
  logic signed [19:0] ray_dir_x;
  logic signed [19:0] ray_dir_y;
  logic [23:0]        wall_dist;
  logic [15:0]        wall_span;
  logic [11:0]        draw_start;
  logic [11:0]        draw_end;
  logic [10:0]        tex_width;
  logic [10:0]        tex_height;

  modport source (
    output valid, op, side, pos_x, pos_y, ray_dir_x, ray_dir_y, wall_dist,
           wall_span, draw_start, draw_end, tex_width, tex_height,
    input  ready
  );
  modport sink (
    input  valid, op, side, pos_x, pos_y, ray_dir_x, ray_dir_y, wall_dist,
           wall_span, draw_start, draw_end, tex_width, tex_height,
    output ready
  );
endinterface

interface rwct_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row;
  logic [1:0]  region;
  logic [23:0] flat_color;
  logic [9:0]  texel_x;
  logic [9:0]  texel_y;
  logic        last;

  modport source (
    output valid, row, region, flat_color, texel_x, texel_y, last,
    input  ready
  );
  modport sink (
    input  valid, row, region, flat_color, texel_x, texel_y, last,
    output ready
  );
endinterface

### rtl/rwct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_ctrl
// Sequencer for column loads and row transfers; owns the output valid flag.
// ----------------------------------------------------------------------------
module rwct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                active,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output rwct_pkg::rwct_cmd_t cmd
);

  rwct_pkg::rwct_state_t state, state_next;
  logic [rwct_pkg::DIV_CNT_W-1:0] div_cnt;
  logic accept;
  logic div_done;

  assign div_done = (div_cnt == rwct_pkg::DIV_CNT_W'(rwct_pkg::DIV_STEPS - 1));
  // Output register frees up when its pixel is taken in the same cycle
  assign in_ready = (state == rwct_pkg::S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rwct_pkg::S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rwct_pkg::S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
      if (cmd.row_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rwct_pkg::S_IDLE: begin
        if (accept && (in_op == rwct_pkg::OP_LOAD)) state_next = rwct_pkg::S_HIT;
      end
      rwct_pkg::S_HIT:  state_next = rwct_pkg::S_FRAC;
      rwct_pkg::S_FRAC: state_next = rwct_pkg::S_DIV;
      rwct_pkg::S_DIV: begin
        if (div_done) state_next = rwct_pkg::S_POS;
      end
      rwct_pkg::S_POS:  state_next = rwct_pkg::S_ARM;
      rwct_pkg::S_ARM:  state_next = rwct_pkg::S_IDLE;
      default:          state_next = rwct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      rwct_pkg::S_IDLE: begin
        cmd.load_capture = accept && (in_op == rwct_pkg::OP_LOAD);
        cmd.row_fire     = accept && (in_op == rwct_pkg::OP_ROW) && active;
      end
      rwct_pkg::S_HIT:  cmd.hit_mul = 1'b1;
      rwct_pkg::S_FRAC: cmd.col_mul = 1'b1;
      rwct_pkg::S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.col_write = 1'b1;
      end
      rwct_pkg::S_POS:  cmd.pos_mul = 1'b1;
      rwct_pkg::S_ARM:  cmd.arm     = 1'b1;
      default:          cmd         = '0;
    endcase
  end

endmodule

### rtl/rwct_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_dp
// Column set-up arithmetic (multipliers, restoring divider) and row stepping.
// ----------------------------------------------------------------------------
module rwct_dp #(
  parameter int SCREEN_ROWS = 480
) (
  input  logic                clk,
  input  logic                rst,
  input  rwct_pkg::rwct_cmd_t cmd,
  output logic                active,
  // column descriptor
  input  logic                side,
  input  logic [23:0]         pos_x,
  input  logic [23:0]         pos_y,
  input  logic signed [19:0]  ray_dir_x,
  input  logic signed [19:0]  ray_dir_y,
  input  logic [23:0]         wall_dist,
  input  logic [15:0]         wall_span,
  input  logic [11:0]         draw_start,
  input  logic [11:0]         draw_end,
  input  logic [10:0]         tex_width,
  input  logic [10:0]         tex_height,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  // pixel
  output logic [11:0]         row,
  output logic [1:0]          region,
  output logic [23:0]         flat_color,
  output logic [9:0]          texel_x,
  output logic [9:0]          texel_y,
  output logic                last
);

  localparam logic signed [16:0] HALF_ROWS = 17'(SCREEN_ROWS / 2);
  localparam logic [11:0]        LAST_ROW  = 12'(SCREEN_ROWS - 1);

  // configuration registers
  logic [23:0] ceiling_color;
  logic [23:0] floor_color;

  // committed column state
  logic [11:0]        row_counter;
  logic signed [31:0] texture_position;
  logic [31:0]        row_step;
  logic [9:0]         texture_column;
  logic [11:0]        wall_top;
  logic [11:0]        wall_bottom;
  logic [10:0]        texture_rows;

  // descriptor being set up
  logic               ld_mirror;
  logic [15:0]        ld_pos_frac;
  logic signed [19:0] ld_rd;
  logic [23:0]        ld_dist;
  logic [15:0]        ld_lh;
  logic [10:0]        ld_tw;
  logic [10:0]        ld_th;
  logic [11:0]        ld_top;
  logic [11:0]        ld_bottom;
  logic [9:0]         ld_col;

  logic [15:0]                          hit_bits;
  logic [10:0]                          col_prod;
  logic [15:0]                          div_rem;
  logic [rwct_pkg::DIV_STEPS-1:0]       div_num;
  logic signed [rwct_pkg::PROD_W-1:0]   pos_prod;

  // set-up combinational terms
  logic signed [rwct_pkg::PROD_W-1:0] hit_full;
  logic [15:0]                        frac;
  logic [26:0]                        col_full;
  logic [16:0]                        rem_sh;
  logic                               q_bit;
  logic signed [16:0]                 offset;
  logic signed [rwct_pkg::PROD_W-1:0] pos_full;

  // row combinational terms
  logic                               in_ceiling;
  logic                               in_wall;
  logic                               is_last;
  logic [14:0]                        tp_int;
  logic [10:0]                        rows_m1;
  logic [9:0]                         ty;
  logic signed [32:0]                 tp_sum;

  // Only the fraction of the hit point matters: the position's integer part
  // never reaches bits 31:16 of the Q.32 sum.
  assign hit_full = $signed({1'b0, ld_dist}) * ld_rd;
  assign frac     = ld_pos_frac + hit_bits;
  assign col_full = frac * ld_tw;

  assign rem_sh = {div_rem, div_num[rwct_pkg::DIV_STEPS-1]};
  assign q_bit  = (rem_sh >= {1'b0, ld_lh});

  assign offset   = $signed({5'd0, ld_top}) - HALF_ROWS + $signed({2'd0, ld_lh[15:1]});
  assign pos_full = offset * $signed({1'b0, div_num});

  assign in_ceiling = (row_counter < wall_top);
  assign in_wall    = !in_ceiling && (row_counter <= wall_bottom);
  assign is_last    = (row_counter >= LAST_ROW);
  assign tp_int     = texture_position[30:16];
  assign rows_m1    = texture_rows - 11'd1;
  assign tp_sum     = $signed({texture_position[31], texture_position})
                    + $signed({row_step[31], row_step});

  always_comb begin
    if (texture_position[31]) begin
      ty = 10'd0;
    end else if (tp_int >= {4'd0, texture_rows}) begin
      ty = rows_m1[9:0];
    end else begin
      ty = tp_int[9:0];
    end
  end

  // control and committed state
  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      ceiling_color    <= '0;
      floor_color      <= '0;
      row_counter      <= '0;
      texture_position <= '0;
      row_step         <= '0;
      texture_column   <= '0;
      wall_top         <= '0;
      wall_bottom      <= '0;
      texture_rows     <= 11'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rwct_pkg::CFG_CEILING: ceiling_color <= cfg_data;
          rwct_pkg::CFG_FLOOR:   floor_color   <= cfg_data;
          default:               ceiling_color <= ceiling_color;
        endcase
      end
      if (cmd.arm) begin
        active           <= 1'b1;
        row_counter      <= '0;
        texture_position <= rwct_pkg::sat_q16(pos_prod);
        row_step         <= {5'd0, div_num};
        texture_column   <= ld_col;
        wall_top         <= ld_top;
        wall_bottom      <= ld_bottom;
        texture_rows     <= ld_th;
      end else if (cmd.row_fire) begin
        if (in_wall) begin
          texture_position <= rwct_pkg::sat_q16(rwct_pkg::PROD_W'(tp_sum));
        end
        if (is_last) begin
          active <= 1'b0;
        end else begin
          row_counter <= row_counter + 12'd1;
        end
      end
    end
  end

  // set-up pipeline and divider
  always_ff @(posedge clk) begin
    if (cmd.load_capture) begin
      ld_pos_frac <= side ? pos_x[15:0] : pos_y[15:0];
      ld_rd       <= side ? ray_dir_x : ray_dir_y;
      ld_mirror   <= side ? (!ray_dir_y[19] && (ray_dir_y != 20'sd0)) : ray_dir_x[19];
      ld_dist     <= wall_dist;
      ld_lh       <= (wall_span == 16'd0) ? 16'd1 : wall_span;
      ld_tw       <= rwct_pkg::tex_size(tex_width);
      ld_th       <= rwct_pkg::tex_size(tex_height);
      ld_top      <= draw_start;
      ld_bottom   <= draw_end;
      div_rem     <= '0;
      div_num     <= {rwct_pkg::tex_size(tex_height), 16'd0};
    end
    if (cmd.hit_mul) begin
      hit_bits <= hit_full[31:16];
    end
    if (cmd.col_mul) begin
      col_prod <= col_full[26:16];
    end
    if (cmd.col_write) begin
      ld_col <= ld_mirror ? 10'(ld_tw - 11'd1 - col_prod) : col_prod[9:0];
    end
    if (cmd.div_step) begin
      div_rem <= q_bit ? 16'(rem_sh - {1'b0, ld_lh}) : rem_sh[15:0];
      div_num <= {div_num[rwct_pkg::DIV_STEPS-2:0], q_bit};
    end
    if (cmd.pos_mul) begin
      pos_prod <= pos_full;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (cmd.row_fire) begin
      row  <= row_counter;
      last <= is_last;
      if (in_ceiling) begin
        region     <= rwct_pkg::REGION_CEILING;
        flat_color <= ceiling_color;
        texel_x    <= '0;
        texel_y    <= '0;
      end else if (in_wall) begin
        region     <= rwct_pkg::REGION_WALL;
        flat_color <= '0;
        texel_x    <= texture_column;
        texel_y    <= ty;
      end else begin
        region     <= rwct_pkg::REGION_FLOOR;
        flat_color <= floor_color;
        texel_x    <= '0;
        texel_y    <= '0;
      end
    end
  end

endmodule

### rtl/raycast_wall_column_texturer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// A load transfer (op 0) takes the hit data of one screen column; the block is
// then busy working out the texture column, the per-row step and the start
// position, in two multiplier stages, then the 27-step restoring divider for
// (tex_height << 16) / wall_span, then one multiply and one saturate stage.
// Once armed, row transfers (op 1) are taken one per cycle while the pixel
// output is not stalled, each giving one pixel top to bottom: ceiling colour,
// wall texel coordinates, then floor colour, with last set on row
// SCREEN_ROWS-1. Row transfers with no armed column give no pixel.
// Colour registers are written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer #(
  parameter int SCREEN_ROWS = 480
) (
  input  logic        clk,
  input  logic        rst,
  rwct_in_if.sink     ray,
  rwct_out_if.source  pixel,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  rwct_pkg::rwct_cmd_t cmd;
  logic active;

  rwct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ray.valid),
    .in_op     (ray.op),
    .active    (active),
    .out_ready (pixel.ready),
    .in_ready  (ray.ready),
    .out_valid (pixel.valid),
    .cmd       (cmd)
  );

  rwct_dp #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .active      (active),
    .side        (ray.side),
    .pos_x       (ray.pos_x),
    .pos_y       (ray.pos_y),
    .ray_dir_x   (ray.ray_dir_x),
    .ray_dir_y   (ray.ray_dir_y),
    .wall_dist   (ray.wall_dist),
    .wall_span   (ray.wall_span),
    .draw_start  (ray.draw_start),
    .draw_end    (ray.draw_end),
    .tex_width   (ray.tex_width),
    .tex_height  (ray.tex_height),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .row         (pixel.row),
    .region      (pixel.region),
    .flat_color  (pixel.flat_color),
    .texel_x     (pixel.texel_x),
    .texel_y     (pixel.texel_y),
    .last        (pixel.last)
  );

endmodule

### rtl/rwct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_checker
// Port-level checks of the wall column texturer, bound to the top level.
// ----------------------------------------------------------------------------
module rwct_checker #(
  parameter int SCREEN_ROWS = 480
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_row,
  input logic        out_last
);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row))
    else $error("pixel changed while stalled");

  // a column load keeps the input side busy while set-up runs
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_op == rwct_pkg::OP_LOAD) |=> !in_ready)
    else $error("transfer taken during column set-up");

  // last marks the bottom screen row only
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_row == 12'(SCREEN_ROWS - 1))
    else $error("last flagged on wrong row");

  // a pixel appears only after a row transfer
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_op == rwct_pkg::OP_ROW)))
    else $error("pixel without row transfer");

endmodule

bind raycast_wall_column_texturer rwct_checker #(
  .SCREEN_ROWS (SCREEN_ROWS)
) u_rwct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (ray.valid),
  .in_ready  (ray.ready),
  .in_op     (ray.op),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_row   (pixel.row),
  .out_last  (pixel.last)
);
